>>> rtl/core/ptw_pkg.sv
// ---------------------------------------------------------------------------
// ptw_pkg
// Shared constants, types and helpers of the four-level page-table walker.
// ---------------------------------------------------------------------------
package ptw_pkg;

  localparam int TABLE_FRAMES = 64;
  localparam int FRAME_W      = $clog2(TABLE_FRAMES);
  localparam int IDX_W        = 9;
  localparam int ADDR_W       = FRAME_W + IDX_W;
  localparam int NF_W         = $clog2(TABLE_FRAMES + 1);

  localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] KEEP_MASK = 64'hFFF0_0000_0000_0FFF;
  localparam logic [63:0] PWU_BITS  = 64'h7;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_LEAF_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME     = 2'd2;

  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
  } store_req_t;

  function automatic logic [63:0] make_entry(input logic [63:0] old,
                                             input logic [63:0] addr);
    return (old & KEEP_MASK) | (addr & ADDR_MASK) | PWU_BITS;
  endfunction

endpackage

>>> rtl/core/ptw_if.sv
// ---------------------------------------------------------------------------
// ptw_if
// Request and result channels of the page-table walker.
// ---------------------------------------------------------------------------
interface ptw_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [47:0] virt_addr;
  logic [51:0] phys_addr;
  logic [3:0]  flag_sel;
  logic        expected;
  modport source(output valid, req_type, virt_addr, phys_addr, flag_sel, expected,
                 input ready);
  modport sink(input valid, req_type, virt_addr, phys_addr, flag_sel, expected,
               output ready);
endinterface

interface ptw_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] mismatch_level;
  modport source(output valid, status, mismatch_level, input ready);
  modport sink(input valid, status, mismatch_level, output ready);
endinterface

>>> rtl/core/ptw_store.sv
// ---------------------------------------------------------------------------
// ptw_store
// Table store with registered reads and a zeroing sweep after reset.
// ---------------------------------------------------------------------------
module ptw_store (
  input  logic                clk,
  input  logic                rst_n,
  input  ptw_pkg::store_req_t req,
  output logic [63:0]         rdata,
  output logic                clr_done
);

  logic [63:0] mem [2**ptw_pkg::ADDR_W];
  logic [ptw_pkg::ADDR_W:0] clr_cnt_r;
  logic [63:0] rdata_r;

  assign clr_done = clr_cnt_r[ptw_pkg::ADDR_W];
  assign rdata    = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt_r[ptw_pkg::ADDR_W-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

endmodule

>>> rtl/core/four_level_page_table_walker.sv
// ---------------------------------------------------------------------------
// four_level_page_table_walker
// Maps pages and checks entry flags over a four-level page-table store.
//
// Requests arrive on in_chan and one result word per request leaves on
// out_chan; both use valid/ready and a word moves when both are high.
// A request walks down from level 4 towards level 1 with at most one store
// read per level while tables exist, then one write per new table or leaf
// entry. A check can stop at level 4; a map can allocate up to three tables.
// The walker returns to idle before it takes the next request: the
// single-port store and the dependency of each level on the entry before
// it rule out overlap. After reset the store is swept to zero, one entry a
// cycle, over all 32768 entries; in_chan.ready stays low during that sweep.
// The root frame is empty and the next free frame is 1. A finished result
// waits in an output register, and the next request is taken while it
// waits; when the receiver stalls, the walker holds its following result
// until the register frees.
// ---------------------------------------------------------------------------
module four_level_page_table_walker (
  input  logic  clk,
  input  logic  rst_n,
  ptw_req_if.sink   in_chan,
  ptw_rsp_if.source out_chan
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_ALLOC = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic        type_r, type_nxt;
  logic [35:0] va_r, va_nxt;
  logic [39:0] pa_r, pa_nxt;
  logic [3:0]  sel_r, sel_nxt;
  logic        exp_r, exp_nxt;
  logic [2:0]  lvl_r, lvl_nxt;
  logic [ptw_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic        oob_r, oob_nxt;
  logic        rz_r, rz_nxt;
  logic [ptw_pkg::NF_W-1:0] nf_r, nf_nxt;
  logic [63:0] old_r, old_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic [2:0]  res_ml_r, res_ml_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic [2:0]  out_ml_r, out_ml_nxt;

  ptw_pkg::store_req_t sreq;
  logic [63:0] rdata;
  logic        clr_done;
  logic [63:0] ent;
  logic [ptw_pkg::IDX_W-1:0] idx;
  logic [ptw_pkg::NF_W-1:0]  spare;
  logic [ptw_pkg::NF_W-1:0]  need;

  ptw_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rdata   (rdata),
    .clr_done(clr_done)
  );

  assign ent   = rz_r ? 64'd0 : rdata;
  assign spare = ptw_pkg::NF_W'(ptw_pkg::TABLE_FRAMES) - nf_r;
  assign need  = ptw_pkg::NF_W'(lvl_r - 3'd1);

  always_comb begin
    case (lvl_r)
      3'd4:    idx = va_r[35:27];
      3'd3:    idx = va_r[26:18];
      3'd2:    idx = va_r[17:9];
      default: idx = va_r[8:0];
    endcase
  end

  assign in_chan.ready           = (st_r == S_IDLE) && clr_done;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_st_r;
  assign out_chan.mismatch_level = out_ml_r;

  always_comb begin
    st_nxt        = st_r;
    type_nxt      = type_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    sel_nxt       = sel_r;
    exp_nxt       = exp_r;
    lvl_nxt       = lvl_r;
    frame_nxt     = frame_r;
    oob_nxt       = oob_r;
    rz_nxt        = rz_r;
    nf_nxt        = nf_r;
    old_nxt       = old_r;
    res_st_nxt    = res_st_r;
    res_ml_nxt    = res_ml_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_ml_nxt    = out_ml_r;
    sreq          = '0;
    sreq.addr     = {frame_r, idx};

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_chan.valid && clr_done) begin
          type_nxt   = in_chan.req_type;
          va_nxt     = in_chan.virt_addr[47:12];
          pa_nxt     = in_chan.phys_addr[51:12];
          sel_nxt    = in_chan.flag_sel;
          exp_nxt    = in_chan.expected;
          lvl_nxt    = 3'd4;
          frame_nxt  = '0;
          oob_nxt    = 1'b0;
          res_st_nxt = ptw_pkg::STATUS_OK;
          res_ml_nxt = 3'd0;
          st_nxt     = S_READ;
        end
      end
      S_READ: begin
        sreq.rd_en = !oob_r;
        rz_nxt     = oob_r;
        st_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (type_r == ptw_pkg::REQ_CHECK) begin
          if (ent[sel_r] != exp_r) begin
            res_ml_nxt = lvl_r;
            st_nxt     = S_DONE;
          end else if (lvl_r == 3'd1 || !ent[0]) begin
            st_nxt = S_DONE;
          end else begin
            frame_nxt = ent[12 +: ptw_pkg::FRAME_W];
            oob_nxt   = |ent[51:12+ptw_pkg::FRAME_W];
            lvl_nxt   = lvl_r - 3'd1;
            st_nxt    = S_READ;
          end
        end else if (lvl_r == 3'd1) begin
          st_nxt = S_DONE;
          if (ent[0]) begin
            res_st_nxt = ptw_pkg::STATUS_LEAF_PRESENT;
          end else if (oob_r) begin
            res_st_nxt = ptw_pkg::STATUS_NO_FRAME;
          end else begin
            sreq.wr_en = 1'b1;
            sreq.wdata = ptw_pkg::make_entry(ent, {12'd0, pa_r, 12'd0});
          end
        end else if (ent[0]) begin
          frame_nxt = ent[12 +: ptw_pkg::FRAME_W];
          oob_nxt   = |ent[51:12+ptw_pkg::FRAME_W];
          lvl_nxt   = lvl_r - 3'd1;
          st_nxt    = S_READ;
        end else if (oob_r || nf_r >= ptw_pkg::NF_W'(ptw_pkg::TABLE_FRAMES) ||
                     spare < need) begin
          res_st_nxt = ptw_pkg::STATUS_NO_FRAME;
          st_nxt     = S_DONE;
        end else begin
          old_nxt = ent;
          st_nxt  = S_ALLOC;
        end
      end
      S_ALLOC: begin
        sreq.wr_en = 1'b1;
        if (lvl_r == 3'd1) begin
          sreq.wdata = ptw_pkg::make_entry(old_r, {12'd0, pa_r, 12'd0});
          st_nxt     = S_DONE;
        end else begin
          sreq.wdata = ptw_pkg::make_entry(old_r, 64'(nf_r) << 12);
          frame_nxt  = nf_r[ptw_pkg::FRAME_W-1:0];
          nf_nxt     = nf_r + 1'b1;
          old_nxt    = '0;
          lvl_nxt    = lvl_r - 3'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_ml_nxt    = res_ml_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      nf_r        <= ptw_pkg::NF_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r   <= type_nxt;
    va_r     <= va_nxt;
    pa_r     <= pa_nxt;
    sel_r    <= sel_nxt;
    exp_r    <= exp_nxt;
    lvl_r    <= lvl_nxt;
    frame_r  <= frame_nxt;
    oob_r    <= oob_nxt;
    rz_r     <= rz_nxt;
    old_r    <= old_nxt;
    res_st_r <= res_st_nxt;
    res_ml_r <= res_ml_nxt;
    out_st_r <= out_st_nxt;
    out_ml_r <= out_ml_nxt;
  end

endmodule
